>>> rtl/assert_macros.svh
// Assertion macros shared by the keyer RTL.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> rtl/mck_pkg.sv
// Shared types, constants and the letter code table of the Morse keyer.
// No dependencies.
`default_nettype none

package mck_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned DotW  = 11;
  localparam int unsigned DurW  = 14;
  localparam int unsigned SymW  = 2;

  localparam logic [DotW-1:0] DotMin   = 11'd1;
  localparam logic [DotW-1:0] DotMax   = 11'd2000;
  localparam logic [DotW-1:0] DotReset = 11'd200;

  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ = 8'h7A;
  localparam logic [CharW-1:0] CaseFold = 8'h20;

  typedef enum logic [SymW-1:0] {
    SYM_GAP  = 2'd0,
    SYM_DOT  = 2'd1,
    SYM_DASH = 2'd2
  } sym_e;

  // One queued character: a word space, or up to four elements sent
  // first-to-last, element 0 in dash[3]
  typedef struct packed {
    logic       is_space;
    logic [2:0] len;
    logic [3:0] dash;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } desc_xfer_t;

  // Letter index 0..25 to {element count, dash flags}
  function automatic logic [6:0] letter_code(input logic [4:0] idx);
    logic [6:0] code;
    unique case (idx)
      5'd0:    code = {3'd2, 4'b0100};  // A
      5'd1:    code = {3'd4, 4'b1000};  // B
      5'd2:    code = {3'd4, 4'b1010};  // C
      5'd3:    code = {3'd3, 4'b1000};  // D
      5'd4:    code = {3'd1, 4'b0000};  // E
      5'd5:    code = {3'd4, 4'b0010};  // F
      5'd6:    code = {3'd3, 4'b1100};  // G
      5'd7:    code = {3'd4, 4'b0000};  // H
      5'd8:    code = {3'd2, 4'b0000};  // I
      5'd9:    code = {3'd4, 4'b0111};  // J
      5'd10:   code = {3'd3, 4'b1010};  // K
      5'd11:   code = {3'd4, 4'b0100};  // L
      5'd12:   code = {3'd2, 4'b1100};  // M
      5'd13:   code = {3'd2, 4'b1000};  // N
      5'd14:   code = {3'd3, 4'b1110};  // O
      5'd15:   code = {3'd4, 4'b0110};  // P
      5'd16:   code = {3'd4, 4'b1101};  // Q
      5'd17:   code = {3'd3, 4'b0100};  // R
      5'd18:   code = {3'd3, 4'b0000};  // S
      5'd19:   code = {3'd1, 4'b1000};  // T
      5'd20:   code = {3'd3, 4'b0010};  // U
      5'd21:   code = {3'd4, 4'b0001};  // V
      5'd22:   code = {3'd3, 4'b0110};  // W
      5'd23:   code = {3'd4, 4'b1001};  // X
      5'd24:   code = {3'd4, 4'b1011};  // Y
      5'd25:   code = {3'd4, 4'b1100};  // Z
      default: code = 7'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mck_if.sv
// Valid/ready channel interfaces for keyer input bytes and LED results.
// Depends on mck_pkg.
`default_nettype none

interface mck_in_if;
  logic                       valid;
  logic                       ready;
  logic [mck_pkg::CharW-1:0]  character;
  logic                       end_of_write;

  modport source (output valid, character, end_of_write, input ready);
  modport sink   (input valid, character, end_of_write, output ready);
endinterface

interface mck_out_if;
  logic                       valid;
  logic                       ready;
  logic                       led_on;
  logic [mck_pkg::DurW-1:0]   duration_ms;
  logic [mck_pkg::SymW-1:0]   symbol;
  logic                       last;

  modport source (output valid, led_on, duration_ms, symbol, last, input ready);
  modport sink   (input valid, led_on, duration_ms, symbol, last, output ready);
endinterface

`default_nettype wire

>>> rtl/morse_character_keyer_unit.sv
// Morse keyer top: front end, character queue, emitter and dot_time register.
// Depends on mck_pkg, mck_if, mck_front, mck_fifo, mck_back, assert_macros.svh.
// First result passes the front-end register, the queue and the emitter register.
// Throughput: one result per cycle from the emitter while out_o is ready; a letter
// gives two results per element (2 to 8), a space one; other bytes are dropped.
// Reset: queue and output empty, dot_time returns to 200.
`default_nettype none

`include "assert_macros.svh"

module morse_character_keyer_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  mck_in_if.sink      in_i,
  mck_out_if.source   out_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic RegDotTime = 1'b0;

  logic [mck_pkg::DotW-1:0] dot_cfg_q;
  logic [mck_pkg::DotW-1:0] dot_eff;
  mck_pkg::desc_xfer_t      push;
  logic                     push_ready;
  mck_pkg::desc_xfer_t      head;
  logic                     pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegDotTime) ? {21'd0, dot_cfg_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_cfg_q <= mck_pkg::DotReset;
    end else if (psel && penable && pwrite && paddr[2] == RegDotTime) begin
      dot_cfg_q <= pwdata[mck_pkg::DotW-1:0];
    end
  end

  always_comb begin
    dot_eff = dot_cfg_q;
    if (dot_cfg_q < mck_pkg::DotMin) begin
      dot_eff = mck_pkg::DotMin;
    end else if (dot_cfg_q > mck_pkg::DotMax) begin
      dot_eff = mck_pkg::DotMax;
    end
  end

  mck_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_ready_i (push_ready),
    .push_o       (push)
  );

  mck_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  mck_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .dot_i  (dot_eff),
    .out_o  (out_o)
  );

  `ASSERT_PROP(a_last_is_gap, clk_i, rst_ni, out_o.valid && out_o.last |-> !out_o.led_on)
  `ASSERT_PROP(a_sym_match, clk_i, rst_ni, out_o.valid |-> out_o.led_on == (out_o.symbol != mck_pkg::SYM_GAP))
  `ASSERT_NEVER(a_zero_dur, clk_i, rst_ni, out_o.valid && out_o.duration_ms == 14'd0)
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop && !head.valid)

endmodule

`default_nettype wire

>>> rtl/mck_front.sv
// Front end: accepts bytes, folds case, classifies and looks up letters.
// Depends on mck_pkg and mck_if.
`default_nettype none

module mck_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  mck_in_if.sink              in_i,
  input  wire                 push_ready_i,
  output mck_pkg::desc_xfer_t push_o
);

  logic                       valid_q, valid_d;
  mck_pkg::desc_t             desc_q, desc_d;
  logic [mck_pkg::CharW-1:0]  ch_up;
  logic                       is_letter;
  logic                       is_space;
  logic [6:0]                 code;
  logic [mck_pkg::CharW-1:0]  offset;
  logic                       in_fire;

  assign in_i.ready = !valid_q || push_ready_i;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    ch_up = in_i.character;
    if (in_i.character >= mck_pkg::ChLowerA && in_i.character <= mck_pkg::ChLowerZ) begin
      ch_up = in_i.character - mck_pkg::CaseFold;
    end
    is_space  = (in_i.character == mck_pkg::ChSpace);
    is_letter = (ch_up >= mck_pkg::ChUpperA) && (ch_up <= mck_pkg::ChUpperZ);
    offset    = ch_up - mck_pkg::ChUpperA;
    code      = mck_pkg::letter_code(offset[4:0]);
  end

  always_comb begin
    valid_d = valid_q;
    desc_d  = desc_q;
    if (in_fire) begin
      // drop bytes that send nothing
      valid_d          = is_space || is_letter;
      desc_d.is_space  = is_space;
      desc_d.len       = code[6:4];
      desc_d.dash      = code[3:0];
    end else if (valid_q && push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  assign push_o.valid = valid_q;
  assign push_o.desc  = desc_q;

endmodule

`default_nettype wire

>>> rtl/mck_fifo.sv
// Two-entry character queue between the front end and the emitter.
// Depends on mck_pkg.
`default_nettype none

module mck_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mck_pkg::desc_xfer_t push_i,
  output logic                push_ready_o,
  output mck_pkg::desc_xfer_t head_o,
  input  wire                 pop_i
);

  mck_pkg::desc_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push;
  logic           pop;

  assign push_ready_o = (count_q != 2'd2);
  assign push         = push_i.valid && push_ready_o;
  assign pop          = pop_i && (count_q != 2'd0);

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.desc  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.desc;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mck_back.sv
// Emitter: walks a queued character; one timed LED result per unstalled cycle.
// Depends on mck_pkg and mck_if.
`default_nettype none

module mck_back (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  mck_pkg::desc_xfer_t       head_i,
  output logic                      pop_o,
  input  wire [mck_pkg::DotW-1:0]   dot_i,
  mck_out_if.source                 out_o
);

  logic                       out_valid_q, out_valid_d;
  logic                       led_q, led_d;
  logic [mck_pkg::DurW-1:0]   dur_q, dur_d;
  mck_pkg::sym_e              sym_q, sym_d;
  logic                       last_q, last_d;
  logic [2:0]                 idx_q, idx_d;
  logic [mck_pkg::DurW-1:0]   dur1, dur3, dur7;
  logic [1:0]                 elem;
  logic [2:0]                 len_m1;
  logic                       is_dash;
  logic                       final_item;
  logic                       load;

  // one, three and seven units
  assign dur1 = {3'd0, dot_i};
  assign dur3 = {2'd0, dot_i, 1'b0} + dur1;
  assign dur7 = {dot_i, 3'd0} - dur1;

  assign elem    = idx_q[2:1];
  assign len_m1  = head_i.desc.len - 3'd1;
  assign is_dash = head_i.desc.dash[2'd3 - elem];
  assign load    = head_i.valid && (!out_valid_q || out_o.ready);

  always_comb begin
    final_item = head_i.desc.is_space || (idx_q[0] && (elem == len_m1[1:0]));
    led_d      = led_q;
    dur_d      = dur_q;
    sym_d      = sym_q;
    last_d     = last_q;
    idx_d      = idx_q;
    pop_o      = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    if (load) begin
      out_valid_d = 1'b1;
      last_d      = final_item;
      if (head_i.desc.is_space) begin
        led_d = 1'b0;
        dur_d = dur7;
        sym_d = mck_pkg::SYM_GAP;
      end else if (!idx_q[0]) begin
        led_d = 1'b1;
        dur_d = is_dash ? dur3 : dur1;
        sym_d = is_dash ? mck_pkg::SYM_DASH : mck_pkg::SYM_DOT;
      end else begin
        // stretch the closing gap to the character gap
        led_d = 1'b0;
        dur_d = final_item ? dur3 : dur1;
        sym_d = mck_pkg::SYM_GAP;
      end
      if (final_item) begin
        pop_o = 1'b1;
        idx_d = 3'd0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    led_q  <= led_d;
    dur_q  <= dur_d;
    sym_q  <= sym_d;
    last_q <= last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.led_on      = led_q;
  assign out_o.duration_ms = dur_q;
  assign out_o.symbol      = sym_q;
  assign out_o.last        = last_q;

endmodule

`default_nettype wire
